>>> hw/rtl/ttrt_pkg.sv
// ttrt_pkg: shared constants, types and helpers of the tick task release table
// used by ttrt_seq and tick_task_release_table_unit; depends on nothing

package ttrt_pkg;

  localparam int NUM_SLOTS    = 16;
  localparam int TICK_BITS    = 16;
  localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W        = TICK_BITS + 1;
  localparam int SLOT_FIELD_W = 4;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_FULL        = 2'd1,
    STATUS_ZERO_PERIOD = 2'd2
  } status_e;

  // one table entry as held in the memory
  typedef struct packed {
    logic [CNT_W-1:0]     cnt;
    logic [TICK_BITS-1:0] period;
  } ttrt_word_t;

  // events from the sequencer to the result stage
  typedef struct packed {
    logic              rel;
    logic [SLOT_W-1:0] rel_slot;
    logic              done;
    logic              add;
    logic [SLOT_W-1:0] add_slot;
    status_e           add_status;
  } ttrt_evt_t;

  // slot index reported modulo the width of the slot field
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(logic [SLOT_W-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[SLOT_FIELD_W-1:0];
  endfunction

endpackage

>>> hw/rtl/ttrt_ram.sv
// ttrt_ram: generic single write port, single read port synchronous ram
// read data registered; depends on nothing

module ttrt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 33,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

>>> hw/rtl/ttrt_seq.sv
// ttrt_seq: slot occupancy, add handling and the read-modify-write tick scan
// depends on ttrt_pkg and ttrt_ram

module ttrt_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       action_i,
  input  logic [15:0]                task_delay_i,
  input  logic [15:0]                task_period_i,
  output logic                       busy_o,
  output ttrt_pkg::ttrt_evt_t        evt_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  localparam logic [ttrt_pkg::SLOT_W-1:0] LAST_IDX =
    ttrt_pkg::SLOT_W'(ttrt_pkg::NUM_SLOTS - 1);

  logic [1:0]                        state_q, state_d;
  logic [ttrt_pkg::SLOT_W-1:0]       idx_q, idx_d;
  logic [ttrt_pkg::NUM_SLOTS-1:0]    used_q, used_d;
  logic                              s1_vld_q;
  logic [ttrt_pkg::SLOT_W-1:0]       s1_idx_q;

  logic                              accept;
  logic                              free_any;
  logic [ttrt_pkg::SLOT_W-1:0]       free_idx;
  logic [31:0]                       delay_w, period_w;
  logic [ttrt_pkg::TICK_BITS-1:0]    delay_t, period_t;
  logic                              add_ok;
  ttrt_pkg::status_e                 add_status;

  logic                              wr_en;
  logic [ttrt_pkg::SLOT_W-1:0]       wr_addr;
  ttrt_pkg::ttrt_word_t              wr_word, rd_word;
  logic [ttrt_pkg::CNT_W-1:0]        cnt_dec;
  logic                              hit;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);

  // operands taken modulo the tick width
  assign delay_w  = 32'(task_delay_i);
  assign period_w = 32'(task_period_i);
  assign delay_t  = delay_w[ttrt_pkg::TICK_BITS-1:0];
  assign period_t = period_w[ttrt_pkg::TICK_BITS-1:0];

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = ttrt_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = ttrt_pkg::SLOT_W'(i);
      end
    end
  end
  assign free_any = !(&used_q);

  always_comb begin
    if (period_t == '0) begin
      add_status = ttrt_pkg::STATUS_ZERO_PERIOD;
    end else if (!free_any) begin
      add_status = ttrt_pkg::STATUS_FULL;
    end else begin
      add_status = ttrt_pkg::STATUS_OK;
    end
  end
  assign add_ok = accept && action_i && (add_status == ttrt_pkg::STATUS_OK);

  // scan write-back: decrement, reload on zero
  assign cnt_dec = rd_word.cnt - ttrt_pkg::CNT_W'(1);
  assign hit     = s1_vld_q && (cnt_dec == '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s1_idx_q;
    wr_word = rd_word;
    if (add_ok) begin
      wr_en          = 1'b1;
      wr_addr        = free_idx;
      wr_word.cnt    = {1'b0, delay_t} + ttrt_pkg::CNT_W'(1);
      wr_word.period = period_t;
    end else if (s1_vld_q) begin
      wr_en       = 1'b1;
      wr_word.cnt = hit ? {1'b0, rd_word.period} : cnt_dec;
    end
  end

  ttrt_ram #(
    .DEPTH (ttrt_pkg::NUM_SLOTS),
    .WIDTH ($bits(ttrt_pkg::ttrt_word_t))
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_word),
    .rd_en_i   (state_q == ST_SCAN),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_word)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    used_d  = used_q;
    if (add_ok) begin
      used_d[free_idx] = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept && !action_i) begin
          state_d = ST_SCAN;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        if (idx_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + ttrt_pkg::SLOT_W'(1);
        end
      end
      ST_DRAIN: state_d = ST_FLUSH;
      ST_FLUSH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      used_q   <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      used_q   <= used_d;
      s1_vld_q <= (state_q == ST_SCAN) && used_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= idx_q;
  end

  always_comb begin
    evt_o            = '0;
    evt_o.rel        = hit;
    evt_o.rel_slot   = s1_idx_q;
    evt_o.done       = (state_q == ST_FLUSH);
    evt_o.add        = accept && action_i;
    evt_o.add_slot   = add_ok ? free_idx : '0;
    evt_o.add_status = add_status;
  end

  // scan write-back and add write never collide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(add_ok && s1_vld_q))
    else $error("add write overlaps scan write-back");

  // a stage-one entry only follows a scan read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> ($past(state_q) == ST_SCAN))
    else $error("write-back without scan read");

  // a granted slot was free before and is used after
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_ok |-> (!used_q[free_idx] ##1 used_q[$past(free_idx)]))
    else $error("granted slot occupancy wrong");

endmodule

>>> hw/rtl/tick_task_release_table_unit.sv
// tick_task_release_table_unit: top level of the tick task release table
// depends on ttrt_pkg and ttrt_seq (which holds the table ram)

// A periodic task table of NUM_SLOTS slots. An item is taken when start is
// high and busy is low. An add item (action 1) takes the lowest free slot and
// answers in the cycle after acceptance with one result: the granted slot and
// status ok, or status table full / zero period (zero period wins) with slot
// 0. An add leaves busy low, so a new item may follow at once. A tick item
// (action 0) walks every slot once through the single read port of the
// table ram, one slot a cycle, and a read-modify-write pipeline decrements
// each used countdown and reloads it from the period when it reaches zero;
// a tick holds busy high until the walk ends. Each slot that hits zero gives
// one release result in ascending slot order; the results trail the walk by
// one release so that the final one can carry last, and the final one
// appears at the end of the walk. A tick with no release gives no result.
// Every result sits on the result ports for exactly one cycle, marked by
// result_valid_o; the receiver cannot stall.

module tick_task_release_table_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              action_i,
  input  logic [15:0]                       task_delay_i,
  input  logic [15:0]                       task_period_i,
  output logic                              result_valid_o,
  output logic                              is_release_o,
  output logic [ttrt_pkg::SLOT_FIELD_W-1:0] slot_o,
  output logic [1:0]                        status_o,
  output logic                              last_o
);

  ttrt_pkg::ttrt_evt_t               evt;

  // one release held back until the next one or the end of the walk
  logic                              pend_vld_q, pend_vld_d;
  logic [ttrt_pkg::SLOT_W-1:0]       pend_slot_q, pend_slot_d;

  // result register
  logic                              out_vld_q, out_vld_d;
  logic                              out_rel_q, out_rel_d;
  logic [ttrt_pkg::SLOT_FIELD_W-1:0] out_slot_q, out_slot_d;
  ttrt_pkg::status_e                 out_status_q, out_status_d;
  logic                              out_last_q, out_last_d;

  ttrt_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .action_i      (action_i),
    .task_delay_i  (task_delay_i),
    .task_period_i (task_period_i),
    .busy_o        (busy),
    .evt_o         (evt)
  );

  always_comb begin
    pend_vld_d   = pend_vld_q;
    pend_slot_d  = pend_slot_q;
    out_vld_d    = 1'b0;
    out_rel_d    = 1'b0;
    out_slot_d   = out_slot_q;
    out_status_d = ttrt_pkg::STATUS_OK;
    out_last_d   = 1'b0;
    // answer to an add goes straight out
    if (evt.add) begin
      out_vld_d    = 1'b1;
      out_slot_d   = ttrt_pkg::slot_field(evt.add_slot);
      out_status_d = evt.add_status;
      out_last_d   = 1'b1;
    end
    // new release: the held one is not the final one
    if (evt.rel) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_rel_d  = 1'b1;
        out_slot_d = ttrt_pkg::slot_field(pend_slot_q);
      end
      pend_vld_d  = 1'b1;
      pend_slot_d = evt.rel_slot;
    end
    // end of walk: the held release is the final one
    if (evt.done) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_rel_d  = 1'b1;
        out_slot_d = ttrt_pkg::slot_field(pend_slot_q);
        out_last_d = 1'b1;
      end
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q  <= pend_slot_d;
    out_rel_q    <= out_rel_d;
    out_slot_q   <= out_slot_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign result_valid_o = out_vld_q;
  assign is_release_o   = out_rel_q;
  assign slot_o         = out_slot_q;
  assign status_o       = out_status_q;
  assign last_o         = out_last_q;

  // release and end of walk never come in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(evt.rel && evt.done))
    else $error("release and end of walk together");

  // no held release when a new item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> !pend_vld_q)
    else $error("held release left over at item acceptance");

  // releases always carry status ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && is_release_o) |-> (status_o == ttrt_pkg::STATUS_OK))
    else $error("release with non-ok status");

  // the walk ends with the held release cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt.done |=> !pend_vld_q)
    else $error("held release survives end of walk");

endmodule

>>> sim/tb_tick_task_release_table_unit.sv
// tb_tick_task_release_table_unit: self-checking testbench of the tick task release table
// drives add and tick items, predicts the release and answer items, checks them in order
// depends on ttrt_pkg and tick_task_release_table_unit

module tb_tick_task_release_table_unit;

  // item codes on action_i
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_ADD  = 1'b1;

  // cycles without any accepted item, in or out, before the run is abandoned
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS_PER_PHASE = 99;

  // one result item as seen on the result ports
  typedef struct {
    logic                              is_release;
    logic [ttrt_pkg::SLOT_FIELD_W-1:0] slot;
    ttrt_pkg::status_e                 status;
    logic                              last;
  } table_result_t;

  // one row of the directed stimulus
  typedef struct {
    logic          action;
    logic [15:0]   delay;
    logic [15:0]   period;
    bit            has_want;
    table_result_t want;
  } stim_row_t;

  logic                              clk_i;
  logic                              rst_ni        = 1'b0;
  logic                              start         = 1'b0;
  logic                              busy;
  logic                              action_i      = ACT_TICK;
  logic [15:0]                       task_delay_i  = '0;
  logic [15:0]                       task_period_i = '0;
  logic                              result_valid_o;
  logic                              is_release_o;
  logic [ttrt_pkg::SLOT_FIELD_W-1:0] slot_o;
  logic [1:0]                        status_o;
  logic                              last_o;

  // typed expectation travelling with the item that is on the input ports
  bit            row_has_want = 1'b0;
  table_result_t row_want;

  // shadow copy of the task table
  bit                             shadow_used[ttrt_pkg::NUM_SLOTS];
  logic [ttrt_pkg::CNT_W-1:0]     shadow_countdown[ttrt_pkg::NUM_SLOTS];
  logic [ttrt_pkg::TICK_BITS-1:0] shadow_period[ttrt_pkg::NUM_SLOTS];

  table_result_t step_results[$];
  table_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  table_result_t head;

  int unsigned n_errors   = 0;
  int unsigned n_adds     = 0;
  int unsigned n_ticks    = 0;
  int unsigned n_releases = 0;
  int unsigned n_answers  = 0;
  int unsigned idle_count = 0;

  tick_task_release_table_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .task_delay_i   (task_delay_i),
    .task_period_i  (task_period_i),
    .result_valid_o (result_valid_o),
    .is_release_o   (is_release_o),
    .slot_o         (slot_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // works out the result items of one accepted item and steps the shadow table
  task automatic predict_table_step(input logic act, input logic [15:0] dly,
                                    input logic [15:0] per);
    int                             free_idx;
    table_result_t                  r;
    logic [ttrt_pkg::TICK_BITS-1:0] dly_w;
    logic [ttrt_pkg::TICK_BITS-1:0] per_w;
    dly_w = ttrt_pkg::TICK_BITS'(dly);
    per_w = ttrt_pkg::TICK_BITS'(per);
    step_results.delete();
    if (act == ACT_ADD) begin
      free_idx = -1;
      for (int i = 0; i < ttrt_pkg::NUM_SLOTS; i++) begin
        if (!shadow_used[i] && free_idx < 0) free_idx = i;
      end
      r.is_release = 1'b0;
      r.slot       = '0;
      r.last       = 1'b1;
      // zero period beats a full table
      if (per_w == '0) begin
        r.status = ttrt_pkg::STATUS_ZERO_PERIOD;
      end else if (free_idx < 0) begin
        r.status = ttrt_pkg::STATUS_FULL;
      end else begin
        shadow_used[free_idx]      = 1'b1;
        shadow_countdown[free_idx] = ttrt_pkg::CNT_W'(dly_w) + 1'b1;
        shadow_period[free_idx]    = per_w;
        r.slot   = ttrt_pkg::SLOT_FIELD_W'(free_idx);
        r.status = ttrt_pkg::STATUS_OK;
      end
      step_results.push_back(r);
    end else begin
      for (int i = 0; i < ttrt_pkg::NUM_SLOTS; i++) begin
        if (shadow_used[i]) begin
          shadow_countdown[i] = shadow_countdown[i] - 1'b1;
          if (shadow_countdown[i] == '0) begin
            shadow_countdown[i] = ttrt_pkg::CNT_W'(shadow_period[i]);
            r.is_release = 1'b1;
            r.slot       = ttrt_pkg::SLOT_FIELD_W'(i);
            r.status     = ttrt_pkg::STATUS_OK;
            r.last       = 1'b0;
            step_results.push_back(r);
          end
        end
      end
      // the final release of a tick carries last
      if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_errors++;
    end
  endtask

  // result check first, then the item accepted at this edge, so that a tick whose
  // last release meets the next item keeps its place in the queue
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_results.size() == 0) begin
          $error("result item with nothing pending: release %0d slot %0d status %0d",
                 is_release_o, slot_o, status_o);
          n_errors++;
        end else begin
          head = pending_results.pop_front();
          check_field("is_release", head.is_release, is_release_o);
          check_field("slot", head.slot, slot_o);
          check_field("status", head.status, status_o);
          check_field("last", head.last, last_o);
        end
        if (is_release_o) n_releases++;
        else n_answers++;
      end
      if (start && !busy) begin
        predict_table_step(action_i, task_delay_i, task_period_i);
        if (action_i == ACT_ADD) n_adds++;
        else n_ticks++;
        // typed rows replace the predicted answer, the shadow table still moves on
        if (row_has_want) pending_results.push_back(row_want);
        else foreach (step_results[k]) pending_results.push_back(step_results[k]);
      end
    end
  end

  // watchdog on cycles where no item moves in either direction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
        $display("stalled for %0d cycles with %0d result items pending",
                 idle_count, pending_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic add_row(input logic act, input logic [15:0] dly, input logic [15:0] per,
                         input bit has_want, input int unsigned slot,
                         input ttrt_pkg::status_e st);
    stim_row_t row;
    row.action          = act;
    row.delay           = dly;
    row.period          = per;
    row.has_want        = has_want;
    row.want.is_release = 1'b0;
    row.want.slot       = ttrt_pkg::SLOT_FIELD_W'(slot);
    row.want.status     = st;
    row.want.last       = 1'b1;
    directed_rows.push_back(row);
  endtask

  // holds an item on the ports until an edge with busy low takes it
  task automatic send_item(input logic act, input logic [15:0] dly, input logic [15:0] per,
                           input bit has_want, input table_result_t want);
    action_i      <= act;
    task_delay_i  <= dly;
    task_period_i <= per;
    row_has_want  <= has_want;
    row_want      <= want;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // random sender gap after an accepted item; pct is the percent chance of going on idling at each step
  task automatic sender_gap(input int unsigned pct);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < pct) begin
      if (!lowered) start <= 1'b0;
      lowered = 1'b1;
      @(posedge clk_i);
    end
  endtask

  // stop sending and wait for every pending result item
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned pct);
    table_result_t none;
    logic [15:0]   per;
    none = '{is_release: 1'b0, slot: '0, status: ttrt_pkg::STATUS_OK, last: 1'b0};
    for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
      // mostly ticks, the rest adds that mostly hit the full table or a zero period
      if ($urandom_range(99) < 22) begin
        per = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
        send_item(ACT_ADD, 16'($urandom), per, 1'b0, none);
      end else begin
        send_item(ACT_TICK, 16'($urandom), 16'($urandom), 1'b0, none);
      end
      sender_gap(pct);
    end
  endtask

  initial begin
    foreach (shadow_used[i]) begin
      shadow_used[i]      = 1'b0;
      shadow_countdown[i] = '0;
      shadow_period[i]    = '0;
    end
    row_want = '{is_release: 1'b0, slot: '0, status: ttrt_pkg::STATUS_OK, last: 1'b0};

    // directed rows: empty table, zero period, extremes, filling, full table
    // tick on empty table
    add_row(ACT_TICK, 16'd0,     16'd0,     1'b0, 0, ttrt_pkg::STATUS_OK);
    add_row(ACT_ADD,  16'd0,     16'd0,     1'b1, 0, ttrt_pkg::STATUS_ZERO_PERIOD);
    add_row(ACT_ADD,  16'd0,     16'd1,     1'b1, 0, ttrt_pkg::STATUS_OK);
    add_row(ACT_TICK, 16'd0,     16'd0,     1'b0, 0, ttrt_pkg::STATUS_OK);
    add_row(ACT_ADD,  16'hFFFF,  16'hFFFF,  1'b1, 1, ttrt_pkg::STATUS_OK);
    add_row(ACT_ADD,  16'd2,     16'd3,     1'b1, 2, ttrt_pkg::STATUS_OK);
    // the other slots get short, different periods so ticks release varied subsets
    for (int k = 3; k < ttrt_pkg::NUM_SLOTS; k++) begin
      add_row(ACT_ADD, 16'(k % 4), 16'(k - 2), 1'b1, k, ttrt_pkg::STATUS_OK);
    end
    add_row(ACT_ADD,  16'd5,     16'd7,     1'b1, 0, ttrt_pkg::STATUS_FULL);
    // zero period wins over a full table
    add_row(ACT_ADD,  16'hFFFF,  16'd0,     1'b1, 0, ttrt_pkg::STATUS_ZERO_PERIOD);
    add_row(ACT_TICK, 16'hFFFF,  16'hFFFF,  1'b0, 0, ttrt_pkg::STATUS_OK);
    add_row(ACT_TICK, 16'd0,     16'd0,     1'b0, 0, ttrt_pkg::STATUS_OK);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].action, directed_rows[r].delay, directed_rows[r].period,
                directed_rows[r].has_want, directed_rows[r].want);
      sender_gap(32);
    end
    drain_results();

    // sender idles a third of the time, then most of the time, then never
    random_phase(32);
    drain_results();
    random_phase(79);
    random_phase(0);

    // let the last walk finish and anything stray show up
    drain_results();
    repeat (ttrt_pkg::NUM_SLOTS + 4) @(posedge clk_i);

    $display("covered %0d adds and %0d ticks on a %0d slot table",
             n_adds, n_ticks, ttrt_pkg::NUM_SLOTS);
    $display("checked %0d add answers and %0d releases, %0d mismatches",
             n_answers, n_releases, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
